// File: rtl/feature_location_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the feature location parser
// Clocked checks with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef FEATURE_LOCATION_PARSER_ASSERT_SVH
`define FEATURE_LOCATION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define FLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/flp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_pkg
// Word types and character codes shared by the location parser modules.
// ----------------------------------------------------------------------------
package flp_pkg;

    localparam logic [7:0]  CHAR_C      = 8'h63;
    localparam logic [7:0]  CHAR_O      = 8'h6F;
    localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;

    localparam logic [1:0]  RUN_MAX     = 2'd3;
    localparam logic [1:0]  RUN_ONE     = 2'd1;
    localparam logic [1:0]  RUN_TWO     = 2'd2;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        interval_valid;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        reverse_strand;
        logic        element_bad;
        logic [15:0] interval_count;
        logic [31:0] feature_start;
        logic [31:0] feature_end;
        logic        end_of_string;
    } t_out_word;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_comma;
        logic       is_last;
        logic       co_pair;
    } t_cls_word;

endpackage

// File: rtl/flp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_front
// Accepts characters and classifies them as digit, comma or other.
// ----------------------------------------------------------------------------
module flp_front
    import flp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_queue_ready,
    output logic      o_push,
    output t_cls_word o_cls
);

    logic [7:0] r_prev;
    logic [7:0] n_prev;
    logic [7:0] digit_off;

    assign o_in_ready = i_queue_ready;
    assign o_push     = i_in_valid && i_queue_ready;
    assign digit_off  = i_in_word.char_byte - CHAR_ZERO;

    always_comb begin
        o_cls.is_digit = (i_in_word.char_byte >= CHAR_ZERO) &&
                         (i_in_word.char_byte <= CHAR_NINE);
        o_cls.digit    = digit_off[3:0];
        o_cls.is_comma = (i_in_word.char_byte == CHAR_COMMA);
        o_cls.is_last  = i_in_word.last_byte;
        o_cls.co_pair  = (r_prev == CHAR_C) && (i_in_word.char_byte == CHAR_O);
        n_prev         = r_prev;
        if (o_push) begin
            n_prev = i_in_word.last_byte ? 8'd0 : i_in_word.char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 8'd0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

// File: rtl/flp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "feature_location_parser_assert.svh"

module flp_queue
    import flp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_word i_word,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cls_word o_word
);

    t_cls_word              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_pop;

    assign o_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `FLP_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, !(i_push && !o_ready), "push into full queue")
    `FLP_ASSERT(a_queue_count_range, i_clk, i_rst_n, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/flp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_back
// Accumulates digit runs, closes elements and registers result words.
// ----------------------------------------------------------------------------
`include "feature_location_parser_assert.svh"

module flp_back
    import flp_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_word_valid,
    input  t_cls_word i_word,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int PW = POSITION_WIDTH;

    logic          r_in_run,   n_in_run;
    logic [1:0]    r_run,      n_run;
    logic [PW-1:0] r_first,    n_first;
    logic [PW-1:0] r_second,   n_second;
    logic          r_nonempty, n_nonempty;
    logic          r_rev,      n_rev;
    logic [15:0]   r_count,    n_count;
    logic [PW-1:0] r_fstart,   n_fstart;
    logic [PW-1:0] r_lend,     n_lend;
    logic          r_out_valid;
    t_out_word     r_out_word;
    t_out_word     n_out_word;

    logic          emit;
    logic          close;
    logic          ivalid;
    logic [PW-1:0] rs;
    logic [PW-1:0] re;
    logic [PW-1:0] acc_src;
    logic [PW+3:0] acc_wide;
    logic [PW-1:0] acc;

    assign o_pop       = i_word_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign acc_src  = (r_run == RUN_TWO) ? r_second : r_first;
    assign acc_wide = ((PW+4)'(acc_src) << 3) + ((PW+4)'(acc_src) << 1)
                    + (PW+4)'(i_word.digit);
    assign acc      = (acc_wide[PW+3:PW] != 4'd0) ? {PW{1'b1}} : acc_wide[PW-1:0];

    always_comb begin
        n_in_run   = r_in_run;
        n_run      = r_run;
        n_first    = r_first;
        n_second   = r_second;
        n_nonempty = r_nonempty;
        n_rev      = r_rev;
        n_count    = r_count;
        n_fstart   = r_fstart;
        n_lend     = r_lend;
        emit       = 1'b0;
        close      = 1'b0;
        ivalid     = 1'b0;
        rs         = '0;
        re         = '0;
        n_out_word = '0;
        if (o_pop) begin
            if (i_word.co_pair) begin
                n_rev = 1'b1;
            end
            if (i_word.is_digit) begin
                n_nonempty = 1'b1;
                if (!r_in_run) begin
                    n_in_run = 1'b1;
                    if (r_run != RUN_MAX) begin
                        n_run = r_run + 2'd1;
                    end
                    if (n_run == RUN_ONE) begin
                        n_first = PW'(i_word.digit);
                    end else if (n_run == RUN_TWO) begin
                        n_second = PW'(i_word.digit);
                    end
                end else if (r_run == RUN_ONE) begin
                    n_first = acc;
                end else if (r_run == RUN_TWO) begin
                    n_second = acc;
                end
            end else if (i_word.is_comma) begin
                n_in_run = 1'b0;
                if (!i_word.is_last) begin
                    if (r_nonempty) begin
                        close = 1'b1;
                    end else begin
                        n_run      = 2'd0;
                        n_first    = '0;
                        n_second   = '0;
                        n_nonempty = 1'b0;
                    end
                end
            end else begin
                n_in_run   = 1'b0;
                n_nonempty = 1'b1;
            end
            if (i_word.is_last) begin
                close = 1'b1;
            end
            if (close) begin
                emit = 1'b1;
                if (n_run == RUN_ONE || n_run == RUN_TWO) begin
                    ivalid = 1'b1;
                    rs     = n_first;
                    re     = (n_run == RUN_TWO) ? n_second : n_first;
                    if (r_count == 16'd0) begin
                        n_fstart = rs;
                    end
                    n_lend = re;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 16'd1;
                    end
                end
                n_out_word.interval_valid = ivalid;
                n_out_word.range_start    = 32'(rs);
                n_out_word.range_end      = 32'(re);
                n_out_word.reverse_strand = n_rev;
                n_out_word.element_bad    = !ivalid && n_nonempty;
                n_out_word.interval_count = n_count;
                n_out_word.feature_start  = 32'(n_fstart);
                n_out_word.feature_end    = 32'(n_lend);
                n_out_word.end_of_string  = i_word.is_last;
                n_in_run   = 1'b0;
                n_run      = 2'd0;
                n_first    = '0;
                n_second   = '0;
                n_nonempty = 1'b0;
            end
            if (i_word.is_last) begin
                n_rev    = 1'b0;
                n_count  = 16'd0;
                n_fstart = '0;
                n_lend   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run    <= 1'b0;
            r_run       <= 2'd0;
            r_first     <= '0;
            r_second    <= '0;
            r_nonempty  <= 1'b0;
            r_rev       <= 1'b0;
            r_count     <= 16'd0;
            r_fstart    <= '0;
            r_lend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_run   <= n_in_run;
            r_run      <= n_run;
            r_first    <= n_first;
            r_second   <= n_second;
            r_nonempty <= n_nonempty;
            r_rev      <= n_rev;
            r_count    <= n_count;
            r_fstart   <= n_fstart;
            r_lend     <= n_lend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= n_out_word;
        end
    end

    `FLP_ASSERT(a_bad_not_valid, i_clk, i_rst_n, r_out_valid |-> !(r_out_word.interval_valid && r_out_word.element_bad), "interval flagged bad")
    `FLP_ASSERT(a_count_nonzero, i_clk, i_rst_n, (r_out_valid && r_out_word.interval_valid) |-> (r_out_word.interval_count != 16'd0), "interval with zero count")
    `FLP_ASSERT(a_last_clears, i_clk, i_rst_n, (o_pop && i_word.is_last) |=> (r_run == 2'd0 && r_count == 16'd0 && !r_rev), "state not cleared after last byte")
    `FLP_ASSERT(a_last_emits, i_clk, i_rst_n, (o_pop && i_word.is_last) |=> (r_out_valid && r_out_word.end_of_string), "last byte gave no result")

endmodule

// File: rtl/feature_location_parser.sv
`timescale 1ns / 1ps
// Path: an accepted character is written into the queue; the single back-end
// accumulate/close step then registers any result word in the output register.
// Throughput: one character per cycle unless output stalls, set by that step.
// Reset: synchronous, active low; clears all parse state, queue and output valid.
// Parse state also returns to its reset values after every last character.
// ----------------------------------------------------------------------------
// feature_location_parser
// Streaming parser of feature location strings into intervals.
// ----------------------------------------------------------------------------
module feature_location_parser
    import flp_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_cls_word front_cls;
    t_cls_word queue_word;
    logic      front_push;
    logic      queue_ready;
    logic      queue_valid;
    logic      back_pop;

    flp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .i_queue_ready (queue_ready),
        .o_push        (front_push),
        .o_cls         (front_cls)
    );

    flp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_word  (front_cls),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_word  (queue_word)
    );

    flp_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (queue_valid),
        .i_word       (queue_word),
        .o_pop        (back_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams location strings through feature_location_parser one character
// per word and checks every result word against a local parser model.
// Covers directed corner cases, random well-formed and broken locations
// with random noise, and a long string sent back to back.
// ----------------------------------------------------------------------------
module tb_top;
    import flp_pkg::*;

    localparam int POS_W     = 32;
    localparam int ITEM_GOAL = 1550;

    typedef logic [7:0] t_char_q [$];
    typedef enum int {FLOW, LIGHT, HALF, CHOKE} t_stall_mode;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    feature_location_parser #(.POSITION_WIDTH(POS_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // parser model state
    logic [7:0]       prev_char;
    logic             in_run;
    logic [1:0]       runs;
    logic [POS_W-1:0] num_a;
    logic [POS_W-1:0] num_b;
    logic             elem_used;
    logic             rev_seen;
    logic [15:0]      n_intervals;
    logic [POS_W-1:0] feat_first;
    logic [POS_W-1:0] feat_last;

    t_out_word   expected_words [$];
    int          mismatches  = 0;
    bit          rush        = 1'b0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = FLOW;
    int          mode_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [POS_W-1:0] scale_up(input logic [POS_W-1:0] n,
                                                 input logic [3:0] d);
        logic [63:0] lim;
        lim = 64'({POS_W{1'b1}});
        if (64'(n) > (lim - 64'(d)) / 64'd10)
            return lim[POS_W-1:0];
        return POS_W'(64'(n) * 64'd10 + 64'(d));
    endfunction

    task automatic clear_element();
        in_run    = 1'b0;
        runs      = '0;
        num_a     = '0;
        num_b     = '0;
        elem_used = 1'b0;
    endtask

    task automatic reset_parse();
        prev_char   = '0;
        clear_element();
        rev_seen    = 1'b0;
        n_intervals = '0;
        feat_first  = '0;
        feat_last   = '0;
    endtask

    task automatic close_element(input logic eos);
        t_out_word w;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        w  = '0;
        lo = '0;
        hi = '0;
        if (runs == RUN_ONE || runs == RUN_TWO) begin
            w.interval_valid = 1'b1;
            lo = num_a;
            hi = (runs == RUN_TWO) ? num_b : num_a;
            if (n_intervals == '0)
                feat_first = lo;
            feat_last = hi;
            if (n_intervals < COUNT_MAX)
                n_intervals++;
        end else if (elem_used) begin
            w.element_bad = 1'b1;
        end
        w.range_start    = 32'(lo);
        w.range_end      = 32'(hi);
        w.reverse_strand = rev_seen;
        w.interval_count = n_intervals;
        w.feature_start  = 32'(feat_first);
        w.feature_end    = 32'(feat_last);
        w.end_of_string  = eos;
        expected_words.push_back(w);
        clear_element();
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic is_last);
        logic [3:0] digit;
        digit = 4'(ch - CHAR_ZERO);
        if (prev_char == CHAR_C && ch == CHAR_O)
            rev_seen = 1'b1;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            elem_used = 1'b1;
            if (!in_run) begin
                in_run = 1'b1;
                if (runs < RUN_MAX)
                    runs++;
                if (runs == RUN_ONE)
                    num_a = POS_W'(digit);
                else if (runs == RUN_TWO)
                    num_b = POS_W'(digit);
            end else if (runs == RUN_ONE) begin
                num_a = scale_up(num_a, digit);
            end else if (runs == RUN_TWO) begin
                num_b = scale_up(num_b, digit);
            end
        end else if (ch == CHAR_COMMA) begin
            in_run = 1'b0;
            if (!is_last) begin
                if (elem_used)
                    close_element(1'b0);
                else
                    clear_element();
            end
        end else begin
            in_run    = 1'b0;
            elem_used = 1'b1;
        end
        prev_char = ch;
        if (is_last) begin
            close_element(1'b1);
            reset_parse();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_out_word exp_w;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end else begin
                exp_w = expected_words.pop_front();
                compare_field("interval_valid", 32'(exp_w.interval_valid),
                              32'(out_word.interval_valid));
                compare_field("range_start", exp_w.range_start, out_word.range_start);
                compare_field("range_end", exp_w.range_end, out_word.range_end);
                compare_field("reverse_strand", 32'(exp_w.reverse_strand),
                              32'(out_word.reverse_strand));
                compare_field("element_bad", 32'(exp_w.element_bad),
                              32'(out_word.element_bad));
                compare_field("interval_count", 32'(exp_w.interval_count),
                              32'(out_word.interval_count));
                compare_field("feature_start", exp_w.feature_start,
                              out_word.feature_start);
                compare_field("feature_end", exp_w.feature_end, out_word.feature_end);
                compare_field("end_of_string", 32'(exp_w.end_of_string),
                              32'(out_word.end_of_string));
            end
        end
    end

    // receiver stalls: switch between random stall modes, or stay ready while rushing
    always @(negedge i_clk) begin
        if (rush) begin
            out_ready = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                FLOW:    out_ready = 1'b1;
                LIGHT:   out_ready = ($urandom_range(0, 3) != 0);
                HALF:    out_ready = 1'($urandom_range(0, 1));
                default: out_ready = (mode_left % 12 == 0);
            endcase
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        int gap;
        if (!rush && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        in_valid          = 1'b1;
        in_word.char_byte = ch;
        in_word.last_byte = is_last;
        do @(posedge i_clk); while (!in_ready);
        parse_char(ch, is_last);
    endtask

    task automatic send_location(input t_char_q chars);
        for (int k = 0; k < chars.size(); k++)
            send_char(chars[k], k == chars.size() - 1);
    endtask

    task automatic push_text(ref t_char_q q, input string s);
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
    endtask

    task automatic push_number(ref t_char_q q);
        int sel;
        int n_digits;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            push_text(q, "4294967295");
        end else if (sel == 1) begin
            push_text(q, "4294967296");
        end else begin
            if (sel < 14)
                n_digits = $urandom_range(1, 4);
            else if (sel < 18)
                n_digits = $urandom_range(5, 9);
            else
                n_digits = $urandom_range(10, 12);
            repeat (n_digits)
                q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_element(ref t_char_q q);
        case ($urandom_range(0, 4))
            0: begin
                push_number(q);
                push_text(q, "..");
                push_number(q);
            end
            1: begin
                push_text(q, "<");
                push_number(q);
                push_text(q, "..>");
                push_number(q);
            end
            2: push_number(q);
            3: begin
                push_number(q);
                push_text(q, "^");
                push_number(q);
            end
            default: begin
                push_text(q, "complement(");
                push_number(q);
                push_text(q, "..");
                push_number(q);
                push_text(q, ")");
            end
        endcase
    endtask

    task automatic build_location(ref t_char_q q);
        int  kind;
        int  n_elem;
        bit  rev;
        bit  grp;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            rev = ($urandom_range(0, 2) == 0);
            grp = 1'($urandom_range(0, 1));
            if (rev)
                push_text(q, "complement(");
            if (grp) begin
                if ($urandom_range(0, 1))
                    push_text(q, "join(");
                else
                    push_text(q, "order(");
            end
            n_elem = grp ? $urandom_range(2, 6) : 1;
            for (int k = 0; k < n_elem; k++) begin
                if (k > 0) begin
                    if ($urandom_range(0, 3) == 0)
                        push_text(q, ", ");
                    else
                        push_text(q, ",");
                end
                push_element(q);
            end
            if (grp)
                push_text(q, ")");
            if (rev)
                push_text(q, ")");
        end else if (kind == 7) begin
            n_elem = $urandom_range(1, 5);
            repeat (n_elem) begin
                case ($urandom_range(0, 3))
                    0: begin
                        push_number(q);
                        push_text(q, "..");
                        push_number(q);
                        push_text(q, "..");
                        push_number(q);
                    end
                    1: ;
                    2: push_text(q, "gap");
                    default: push_element(q);
                endcase
                push_text(q, ",");
            end
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: b = 8'($urandom_range(0, 255));
                    1: b = CHAR_ZERO + 8'($urandom_range(0, 9));
                    2: b = CHAR_COMMA;
                    default: b = $urandom_range(0, 1) ? CHAR_C : CHAR_O;
                endcase
                q.push_back(b);
            end
        end else begin
            case ($urandom_range(0, 2))
                0: push_text(q, "c");
                1: push_text(q, "o1");
                default: push_number(q);
            endcase
        end
    endtask

    task automatic test_directed();
        t_char_q q;
        push_text(q, "co1,2.3");
        send_location(q);
        q.delete();
        push_text(q, "99999999999");
        send_location(q);
        q.delete();
        q.push_back(8'h00);
        push_text(q, "1.2.3,x");
        q.push_back(8'hFF);
        send_location(q);
        q.delete();
        push_text(q, ",");
        send_location(q);
    endtask

    task automatic test_random_locations();
        t_char_q q;
        int sent;
        sent = 0;
        while (sent < ITEM_GOAL - 120) begin
            q.delete();
            build_location(q);
            send_location(q);
            sent += q.size();
        end
    endtask

    task automatic test_back_to_back();
        t_char_q q;
        rush = 1'b1;
        for (int k = 0; k < 40; k++) begin
            q.push_back(CHAR_ZERO + 8'(k % 10));
            q.push_back(CHAR_COMMA);
        end
        push_text(q, "3..8");
        send_location(q);
        rush = 1'b0;
    endtask

    initial begin
        reset_parse();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        test_directed();
        test_random_locations();
        test_back_to_back();

        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: feature_location_parser.f
+incdir+rtl
rtl/flp_pkg.sv
rtl/flp_front.sv
rtl/flp_queue.sv
rtl/flp_back.sv
rtl/feature_location_parser.sv
bench/tb_top.sv
